// File: rtl/core/chdg_pkg.sv
// ----------------------------------------------------------------------------
// chdg_pkg
// Shared types and constants for the compass heading CORDIC pipeline.
// ----------------------------------------------------------------------------
package chdg_pkg;

  // Number of micro-rotations, capped by the length of the angle table
  localparam int CORDIC_STEPS  = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STEPS         = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Datapath widths
  localparam int RAW_W     = 16;   // signed axis reading
  localparam int PRESCALE  = 24;   // fraction bits added before rotation
  localparam int VEC_W     = 44;   // signed x/y working width (covers CORDIC gain)
  localparam int ANG_W     = 32;   // binary angle, 2^32 is a full turn
  localparam int SHIFT_W   = 5;    // shift index per micro-rotation
  localparam int HEAD_W    = 15;   // heading, degrees with 6 fraction bits
  localparam int PROD_W    = 48;   // angle times full-scale heading plus rounding

  // Full turn in 1/64 degree, half LSB of the binary angle product
  localparam logic [HEAD_W-1:0] HEADING_FULL = 15'd23040;
  localparam logic [PROD_W-1:0] ROUND_HALF   = 48'h0000_8000_0000;
  localparam logic [ANG_W-1:0]  HALF_TURN    = 32'h8000_0000;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [ANG_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // One vector in flight through the rotation stages
  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic [ANG_W-1:0]         acc;
  } vec_t;

endpackage

// File: rtl/core/chdg_cordic_stage.sv
// ----------------------------------------------------------------------------
// chdg_cordic_stage
// One registered vectoring micro-rotation: drive y toward zero and
// accumulate the rotated angle.
// ----------------------------------------------------------------------------
module chdg_cordic_stage
  import chdg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [SHIFT_W-1:0] shift,
  input  logic [ANG_W-1:0]   angle,
  input  vec_t               vec_in,
  output vec_t               vec_out
);

  logic                    pos;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  vec_t                    vec_next;

  // Rotate by the sign of y
  always_comb begin
    pos            = ~vec_in.y[VEC_W-1];
    xs             = vec_in.x >>> shift;
    ys             = vec_in.y >>> shift;
    vec_next       = vec_in;
    if (pos) begin
      vec_next.x   = vec_in.x + ys;
      vec_next.y   = vec_in.y - xs;
      vec_next.acc = vec_in.acc + angle;
    end else begin
      vec_next.x   = vec_in.x - ys;
      vec_next.y   = vec_in.y + xs;
      vec_next.acc = vec_in.acc - angle;
    end
  end

  // Advance the stage register when the pipeline moves
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_out.valid <= 1'b0;
    end else if (advance) begin
      vec_out.valid <= vec_next.valid;
    end
    if (advance) begin
      vec_out.zero <= vec_next.zero;
      vec_out.x    <= vec_next.x;
      vec_out.y    <= vec_next.y;
      vec_out.acc  <= vec_next.acc;
    end
  end

endmodule

// File: rtl/core/compass_heading_atan2_core.sv
// ----------------------------------------------------------------------------
// compass_heading_atan2_core
// Heading atan2(Y, X) in degrees from raw magnetometer bytes, by a fully
// pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[31:0]: x_low_byte, x_high_byte, y_low_byte, y_high_byte
//  m_axis    out        tdata[15:0]: heading[14:0], zero pad
//
//  One sample per clock while m_axis is not stalled; the registers are the input
//  fold, one stage per micro-rotation, the scale multiply, and the round and wrap.
//  Reset clears every stage valid bit; no payload is cleared.
//  The whole pipeline holds while a result waits on m_axis; bubbles move
//  along with the data and any stage may be empty.
// ----------------------------------------------------------------------------
module compass_heading_atan2_core
  import chdg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_low_byte, x_high_byte, y_low_byte, y_high_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // heading[14:0], zero pad
);

  logic                    advance;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W:0]   fold_x;
  logic signed [RAW_W:0]   fold_y;
  logic                    neg;
  vec_t                    front_next;
  vec_t                    stage [STEPS+1];

  logic                    mul_valid;
  logic                    mul_zero;
  logic [PROD_W-1:0]       mul_prod;
  logic [PROD_W-1:0]       rnd_sum;
  logic [PROD_W-ANG_W-1:0] rnd_head;
  logic [HEAD_W-1:0]       head_next;
  logic [HEAD_W-1:0]       heading;

  // Move the pipeline unless the output holds an untaken result
  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = advance;

  // Join bytes, fold the left half plane onto the right, scale up
  always_comb begin
    raw_x            = s_axis_tdata[15:0];
    raw_y            = s_axis_tdata[31:16];
    neg              = raw_x[RAW_W-1];
    fold_x           = neg ? -{raw_x[RAW_W-1], raw_x} : {raw_x[RAW_W-1], raw_x};
    fold_y           = neg ? -{raw_y[RAW_W-1], raw_y} : {raw_y[RAW_W-1], raw_y};
    front_next.valid = s_axis_tvalid;
    front_next.zero  = (raw_x == '0) && (raw_y == '0);
    front_next.x     = {{(VEC_W-RAW_W-1-PRESCALE){fold_x[RAW_W]}}, fold_x, {PRESCALE{1'b0}}};
    front_next.y     = {{(VEC_W-RAW_W-1-PRESCALE){fold_y[RAW_W]}}, fold_y, {PRESCALE{1'b0}}};
    front_next.acc   = neg ? HALF_TURN : '0;
  end

  // Hold the folded vector
  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else if (advance) begin
      stage[0].valid <= front_next.valid;
    end
    if (advance) begin
      stage[0].zero <= front_next.zero;
      stage[0].x    <= front_next.x;
      stage[0].y    <= front_next.y;
      stage[0].acc  <= front_next.acc;
    end
  end

  // One register stage per micro-rotation
  for (genvar g = 0; g < STEPS; g++) begin : g_rot
    chdg_cordic_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .shift   (SHIFT_W'(g)),
      .angle   (ATAN_TURNS[g]),
      .vec_in  (stage[g]),
      .vec_out (stage[g+1])
    );
  end

  // Scale the binary angle to 1/64 degree units
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= stage[STEPS].valid;
    end
    if (advance) begin
      mul_zero <= stage[STEPS].zero;
      mul_prod <= PROD_W'(stage[STEPS].acc) * PROD_W'(HEADING_FULL);
    end
  end

  // Round to nearest, wrap a full turn and the zero vector to 0
  always_comb begin
    rnd_sum  = mul_prod + ROUND_HALF;
    rnd_head = rnd_sum[PROD_W-1:ANG_W];
    if (mul_zero || (rnd_head >= (PROD_W-ANG_W)'(HEADING_FULL))) begin
      head_next = '0;
    end else begin
      head_next = rnd_head[HEAD_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= mul_valid;
    end
    if (advance) begin
      heading <= head_next;
    end
  end

  assign m_axis_tdata = {1'b0, heading};

endmodule
